// File: design/bf_pkg.sv
`default_nettype none

package bf_pkg;

    localparam int WEIGHT_W  = 25;
    localparam int DIST_W    = 32;
    localparam int NODE_W    = 6;
    localparam int CNT_W     = 7;
    localparam int SRC_W     = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 7;

    localparam logic signed [DIST_W-1:0] NO_EDGE  = 32'sd10000000;
    localparam logic signed [DIST_W-1:0] DIST_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DIST_W-1:0] DIST_MIN = 32'sh8000_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_NODE = 1'b1;

    typedef enum logic [9:0] {
        S_LOAD   = 10'b00_0000_0001,
        S_INIT   = 10'b00_0000_0010,
        S_ROW    = 10'b00_0000_0100,
        S_ROWCHK = 10'b00_0000_1000,
        S_EDGE   = 10'b00_0001_0000,
        S_DRAIN  = 10'b00_0010_0000,
        S_DECIDE = 10'b00_0100_0000,
        S_EMRD   = 10'b00_1000_0000,
        S_EMLD   = 10'b01_0000_0000,
        S_NEG    = 10'b10_0000_0000
    } state_t;

    typedef struct packed {
        logic                     hit;
        logic signed [DIST_W-1:0] cand;
    } relax_res_t;

endpackage

`default_nettype wire

// File: design/bellman_ford_shortest_paths.sv
`default_nettype none

// Channel | Signals                                     | Direction
// --------+---------------------------------------------+----------
// config  | cfg_write, cfg_index, cfg_data              | in
// matrix  | in_valid, in_stall, edge_weight, final_entry| in
// result  | out_valid, out_stall, node, distance,       | out
//         | negative_cycle, run_end                     |
//
// Loading writes each matrix entry into the weight memory as its beat is taken.
// A run: init, then per round a read and a check per row plus an edge sweep per
// reachable row (one edge a cycle), a drain when row n-1 is reachable, a decide;
// up to n rounds incl. the negative cycle check, then a read and load per result.
// Reset sets node_count to 64, source_node to 0 and the load counter to zero.
// in_stall stays high from the final beat until the last result is registered.

module bellman_ford_shortest_paths
    import bf_pkg::*;
#(
    parameter int MAX_NODES = 64
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_write,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_W-1:0]           cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic signed [WEIGHT_W-1:0] edge_weight,
    input  wire logic                       final_entry,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [NODE_W-1:0]               node,
    output logic signed [DIST_W-1:0]        distance,
    output logic                            negative_cycle,
    output logic                            run_end
);

    localparam int AW    = $clog2(MAX_NODES);
    localparam int NW    = $clog2(MAX_NODES + 1);
    localparam int DEPTH = MAX_NODES * MAX_NODES;
    localparam int WAW   = $clog2(DEPTH);

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         node_count_reg, node_count_next;
    logic [SRC_W-1:0]         source_reg, source_next;
    logic [WAW-1:0]           load_cnt_reg, load_cnt_next;
    logic [NW-1:0]            n_reg, n_next;
    logic [AW-1:0]            u_reg, u_next;
    logic [AW-1:0]            v_reg, v_next;
    logic [WAW-1:0]           row_base_reg, row_base_next;
    logic [AW-1:0]            rounds_reg, rounds_next;
    logic                     check_reg, check_next;
    logic                     changed_reg, changed_next;
    logic [MAX_NODES-1:0]     reach_reg, reach_next;
    logic                     b_valid_reg, b_valid_next;
    logic [AW-1:0]            b_v_reg;
    logic [AW-1:0]            rd_addr_reg;
    logic                     fwd_valid_reg;
    logic [AW-1:0]            fwd_addr_reg;
    logic signed [DIST_W-1:0] fwd_data_reg;
    logic signed [DIST_W-1:0] du_reg;
    logic                     out_valid_reg, out_valid_next;
    logic [NODE_W-1:0]        node_reg;
    logic signed [DIST_W-1:0] dist_reg;
    logic                     neg_reg;
    logic                     end_reg;

    logic                     wt_we;
    logic [WAW-1:0]           wt_raddr;
    logic [WEIGHT_W-1:0]      wt_rdata;
    logic                     dist_we;
    logic [AW-1:0]            dist_waddr;
    logic signed [DIST_W-1:0] dist_wdata;
    logic [AW-1:0]            dist_raddr;
    logic [DIST_W-1:0]        dist_rdata;
    logic signed [DIST_W-1:0] dv;
    logic [NW-1:0]            n_eff;
    logic [AW-1:0]            n_m1;
    logic                     src_in;
    logic                     du_load;
    logic                     out_load;
    logic                     out_load_neg;
    logic signed [DIST_W-1:0] dist_clamped;
    relax_res_t               res;

    always_comb
    begin
        if (node_count_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (32'(node_count_reg) > 32'(MAX_NODES))
        begin
            n_eff = NW'(MAX_NODES);
        end
        else
        begin
            n_eff = NW'(node_count_reg);
        end
    end

    assign n_m1   = AW'(n_reg - NW'(1));
    assign src_in = (32'(source_reg) < 32'(n_reg));

    // a write in the cycle of the read is not in the RAM output yet
    assign dv = (fwd_valid_reg && (fwd_addr_reg == rd_addr_reg)) ?
                fwd_data_reg : $signed(dist_rdata);

    assign dist_clamped = !reach_reg[v_reg] ? NO_EDGE :
                          (dv > NO_EDGE)    ? NO_EDGE : dv;

    bf_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (DEPTH)
    ) u_weight_ram (
        .clk   (clk),
        .we    (wt_we),
        .waddr (load_cnt_reg),
        .wdata (edge_weight),
        .raddr (wt_raddr),
        .rdata (wt_rdata)
    );

    bf_ram #(
        .WIDTH (DIST_W),
        .DEPTH (MAX_NODES)
    ) u_dist_ram (
        .clk   (clk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (dist_wdata),
        .raddr (dist_raddr),
        .rdata (dist_rdata)
    );

    bf_relax u_relax (
        .valid   (b_valid_reg),
        .reach_v (reach_reg[b_v_reg]),
        .du      (du_reg),
        .w       ($signed(wt_rdata)),
        .dv      (dv),
        .res     (res)
    );

    always_comb
    begin
        state_next      = state_reg;
        node_count_next = node_count_reg;
        source_next     = source_reg;
        load_cnt_next   = load_cnt_reg;
        n_next          = n_reg;
        u_next          = u_reg;
        v_next          = v_reg;
        row_base_next   = row_base_reg;
        rounds_next     = rounds_reg;
        check_next      = check_reg;
        changed_next    = changed_reg;
        reach_next      = reach_reg;
        b_valid_next    = 1'b0;
        out_valid_next  = out_valid_reg && out_stall;
        wt_we           = 1'b0;
        wt_raddr        = row_base_reg + WAW'(v_reg);
        dist_we         = 1'b0;
        dist_waddr      = b_v_reg;
        dist_wdata      = res.cand;
        dist_raddr      = v_reg;
        du_load         = 1'b0;
        out_load        = 1'b0;
        out_load_neg    = 1'b0;

        if (cfg_write)
        begin
            case (cfg_index)
                CFG_NODE_COUNT:  node_count_next = cfg_data;
                CFG_SOURCE_NODE: source_next     = cfg_data[SRC_W-1:0];
                default:         ;
            endcase
        end

        // second half of the edge pipe: weight and dist[v] are back
        if (res.hit)
        begin
            changed_next = 1'b1;
            if (!check_reg)
            begin
                dist_we             = 1'b1;
                reach_next[b_v_reg] = 1'b1;
            end
        end

        case (state_reg)
            S_LOAD:
            begin
                if (in_valid)
                begin
                    wt_we = 1'b1;
                    if (load_cnt_reg == WAW'(DEPTH - 1))
                    begin
                        load_cnt_next = '0;
                    end
                    else
                    begin
                        load_cnt_next = load_cnt_reg + WAW'(1);
                    end
                    if (final_entry)
                    begin
                        load_cnt_next = '0;
                        n_next        = n_eff;
                        state_next    = S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                reach_next = '0;
                if (src_in)
                begin
                    reach_next[AW'(source_reg)] = 1'b1;
                end
                dist_we       = 1'b1;
                dist_waddr    = AW'(source_reg);
                dist_wdata    = '0;
                rounds_next   = '0;
                check_next    = (n_reg == NW'(1));
                changed_next  = 1'b0;
                u_next        = '0;
                row_base_next = '0;
                state_next    = S_ROW;
            end
            S_ROW:
            begin
                dist_raddr = u_reg;
                state_next = S_ROWCHK;
            end
            S_ROWCHK:
            begin
                du_load = 1'b1;
                if (reach_reg[u_reg])
                begin
                    v_next     = '0;
                    state_next = S_EDGE;
                end
                else if (u_reg == n_m1)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    u_next        = u_reg + AW'(1);
                    row_base_next = row_base_reg + WAW'(n_reg);
                    state_next    = S_ROW;
                end
            end
            S_EDGE:
            begin
                dist_raddr   = v_reg;
                b_valid_next = 1'b1;
                if (v_reg == n_m1)
                begin
                    if (u_reg == n_m1)
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        u_next        = u_reg + AW'(1);
                        row_base_next = row_base_reg + WAW'(n_reg);
                        state_next    = S_ROW;
                    end
                end
                else
                begin
                    v_next = v_reg + AW'(1);
                end
            end
            S_DRAIN:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (check_reg && changed_reg)
                begin
                    state_next = S_NEG;
                end
                else if (check_reg || !changed_reg)
                begin
                    v_next     = '0;
                    state_next = S_EMRD;
                end
                else
                begin
                    rounds_next = rounds_reg + AW'(1);
                    if ((rounds_reg + AW'(1)) == n_m1)
                    begin
                        check_next = 1'b1;
                    end
                    changed_next  = 1'b0;
                    u_next        = '0;
                    row_base_next = '0;
                    state_next    = S_ROW;
                end
            end
            S_EMRD:
            begin
                dist_raddr = v_reg;
                state_next = S_EMLD;
            end
            S_EMLD:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    if (v_reg == n_m1)
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        v_next     = v_reg + AW'(1);
                        state_next = S_EMRD;
                    end
                end
            end
            S_NEG:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load_neg   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            node_count_reg <= CNT_W'(64);
            source_reg     <= '0;
            load_cnt_reg   <= '0;
            n_reg          <= NW'(1);
            u_reg          <= '0;
            v_reg          <= '0;
            row_base_reg   <= '0;
            rounds_reg     <= '0;
            check_reg      <= 1'b0;
            changed_reg    <= 1'b0;
            reach_reg      <= '0;
            b_valid_reg    <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            source_reg     <= source_next;
            load_cnt_reg   <= load_cnt_next;
            n_reg          <= n_next;
            u_reg          <= u_next;
            v_reg          <= v_next;
            row_base_reg   <= row_base_next;
            rounds_reg     <= rounds_next;
            check_reg      <= check_next;
            changed_reg    <= changed_next;
            reach_reg      <= reach_next;
            b_valid_reg    <= b_valid_next;
            fwd_valid_reg  <= dist_we;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_v_reg      <= v_reg;
        rd_addr_reg  <= dist_raddr;
        fwd_addr_reg <= dist_waddr;
        fwd_data_reg <= dist_wdata;
        if (du_load)
        begin
            du_reg <= dv;
        end
        else if (res.hit && !check_reg && (b_v_reg == u_reg))
        begin
            // self loop improved dist[u] mid-row
            du_reg <= res.cand;
        end
        if (out_load)
        begin
            node_reg <= NODE_W'(v_reg);
            dist_reg <= dist_clamped;
            neg_reg  <= 1'b0;
            end_reg  <= (v_reg == n_m1);
        end
        else if (out_load_neg)
        begin
            node_reg <= '0;
            dist_reg <= '0;
            neg_reg  <= 1'b1;
            end_reg  <= 1'b1;
        end
    end

    assign in_stall       = (state_reg != S_LOAD);
    assign out_valid      = out_valid_reg;
    assign node           = node_reg;
    assign distance       = dist_reg;
    assign negative_cycle = neg_reg;
    assign run_end        = end_reg;

`ifndef SYNTHESIS
    ast_check_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (check_reg && b_valid_reg) |-> !dist_we)
        else $error("distance written during cycle check");

    ast_neg_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && negative_cycle) |-> (run_end && (node == '0) && (distance == '0)))
        else $error("malformed negative cycle beat");

    ast_final_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && final_entry) |=> (state_reg == S_INIT))
        else $error("final beat did not start a run");

    ast_pipe_origin: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> $past(state_reg == S_EDGE))
        else $error("edge stage valid without issue");

    ast_dist_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (distance <= NO_EDGE))
        else $error("reported distance above clamp");
`endif

endmodule

`default_nettype wire

// File: design/bf_ram.sv
`default_nettype none

module bf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old word when it collides with a write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: design/bf_relax.sv
`default_nettype none

module bf_relax
    import bf_pkg::*;
(
    input  wire logic                       valid,
    input  wire logic                       reach_v,
    input  wire logic signed [DIST_W-1:0]   du,
    input  wire logic signed [WEIGHT_W-1:0] w,
    input  wire logic signed [DIST_W-1:0]   dv,
    output relax_res_t                      res
);

    logic signed [DIST_W-1:0] w_ext;
    logic signed [DIST_W:0]   sum;
    logic signed [DIST_W-1:0] cand;
    logic                     has_edge;

    assign w_ext    = DIST_W'(w);
    assign has_edge = (w_ext < NO_EDGE);
    assign sum      = (DIST_W+1)'(du) + (DIST_W+1)'(w_ext);

    // two top bits differ on overflow; sign of the wide sum picks the rail
    always_comb
    begin
        if (sum[DIST_W] != sum[DIST_W-1])
        begin
            cand = sum[DIST_W] ? DIST_MIN : DIST_MAX;
        end
        else
        begin
            cand = sum[DIST_W-1:0];
        end
    end

    assign res.cand = cand;
    assign res.hit  = valid && has_edge && (!reach_v || (cand < dv));

endmodule

`default_nettype wire

// File: verif/tb_bellman_ford_shortest_paths.sv
`timescale 1ns / 1ps

module tb_bellman_ford_shortest_paths;

    import bf_pkg::*;

    localparam int MAX_N       = 64;
    localparam int STORE_DEPTH = MAX_N * MAX_N;
    localparam int CYCLE_LIMIT = 2_000_000;

    localparam logic signed [WEIGHT_W-1:0] W_MIN = 25'h100_0000;
    localparam logic signed [WEIGHT_W-1:0] W_MAX = 25'h0FF_FFFF;

    typedef struct packed {
        logic [NODE_W-1:0]        node;
        logic signed [DIST_W-1:0] distance;
        logic                     negative_cycle;
        logic                     run_end;
    } result_t;

    typedef struct packed {
        logic                       set_cfg;
        logic [CFG_W-1:0]           cnt;
        logic [CFG_W-1:0]           src;
        logic signed [WEIGHT_W-1:0] w;
        logic                       fin;
        logic                       typed;
        result_t                    want;
    } row_t;

    localparam result_t NO_RESULT = '0;
    localparam result_t R_ZERO    = '{6'd0, 32'sd0, 1'b0, 1'b1};
    localparam result_t R_CYCLE   = '{6'd0, 32'sd0, 1'b1, 1'b1};
    localparam result_t R_UNREACH = '{6'd0, NO_EDGE, 1'b0, 1'b1};

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_W-1:0]           cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic signed [WEIGHT_W-1:0] edge_weight = '0;
    logic                       final_entry = 1'b0;
    logic                       out_valid;
    logic                       out_stall;
    logic [NODE_W-1:0]          node;
    logic signed [DIST_W-1:0]   distance;
    logic                       negative_cycle;
    logic                       run_end;

    // predictor state
    logic signed [DIST_W-1:0] edge_mem [0:STORE_DEPTH-1];
    bit                       loaded [0:STORE_DEPTH-1];
    logic signed [DIST_W-1:0] best_dist [0:MAX_N-1];
    bit                       reach_ok [0:MAX_N-1];
    int                       load_ptr = 0;
    logic [CFG_W-1:0]         nodes_reg = 7'd64;
    logic [SRC_W-1:0]         src_reg = '0;

    result_t pending_results [$];
    int      bad_results = 0;
    int      cycle_count = 0;
    bit      no_idle = 1'b0;
    row_t    plan [23];

    bellman_ford_shortest_paths uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .edge_weight    (edge_weight),
        .final_entry    (final_entry),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .node           (node),
        .distance       (distance),
        .negative_cycle (negative_cycle),
        .run_end        (run_end)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int clip_nodes(logic [CFG_W-1:0] cnt);
        if (cnt == 0)
            return 1;
        if (cnt > MAX_N)
            return MAX_N;
        return int'(cnt);
    endfunction

    function automatic logic signed [DIST_W-1:0] sat_sum(logic signed [DIST_W-1:0] a,
                                                         logic signed [DIST_W-1:0] b);
        longint s;
        s = longint'(a) + longint'(b);
        if (s < longint'(DIST_MIN))
            return DIST_MIN;
        if (s > longint'(DIST_MAX))
            return DIST_MAX;
        return s[DIST_W-1:0];
    endfunction

    // one sweep over all edges; with apply clear it only reports whether any edge improves
    function automatic bit relax_pass(int n, bit apply);
        logic signed [DIST_W-1:0] w;
        logic signed [DIST_W-1:0] cand;
        bit                       any;
        any = 1'b0;
        for (int u = 0; u < n; u++)
        begin
            if (!reach_ok[u])
                continue;
            for (int v = 0; v < n; v++)
            begin
                w = edge_mem[u * n + v];
                if (w >= NO_EDGE)
                    continue;
                cand = sat_sum(best_dist[u], w);
                if (!reach_ok[v] || cand < best_dist[v])
                begin
                    any = 1'b1;
                    if (!apply)
                        return 1'b1;
                    best_dist[v] = cand;
                    reach_ok[v] = 1'b1;
                end
            end
        end
        return any;
    endfunction

    task automatic take_weight(logic signed [WEIGHT_W-1:0] w, bit fin, bit keep);
        int      n;
        int      rounds;
        bit      neg;
        result_t r;
        logic signed [DIST_W-1:0] d;
        edge_mem[load_ptr] = w;
        loaded[load_ptr] = 1'b1;
        load_ptr = (load_ptr + 1) % STORE_DEPTH;
        if (!fin)
            return;
        load_ptr = 0;
        n = clip_nodes(nodes_reg);
        for (int i = 0; i < MAX_N; i++)
        begin
            best_dist[i] = '0;
            reach_ok[i] = 1'b0;
        end
        if (src_reg < n)
            reach_ok[src_reg] = 1'b1;
        rounds = 0;
        while (rounds < n - 1)
        begin
            if (!relax_pass(n, 1'b1))
                break;
            rounds++;
        end
        neg = (rounds == n - 1) ? relax_pass(n, 1'b0) : 1'b0;
        if (!keep)
            return;
        if (neg)
        begin
            pending_results.push_back(R_CYCLE);
            return;
        end
        for (int i = 0; i < n; i++)
        begin
            d = reach_ok[i] ? best_dist[i] : NO_EDGE;
            if (d > NO_EDGE)
                d = NO_EDGE;
            r.node = NODE_W'(i);
            r.distance = d;
            r.negative_cycle = 1'b0;
            r.run_end = (i == n - 1);
            pending_results.push_back(r);
        end
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(99, 0);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // safe graphs keep every cycle positive: back edges and self loops are large
    function automatic logic signed [WEIGHT_W-1:0] pick_weight(bit safe, bit fwd);
        int r;
        int mag;
        r = $urandom_range(99, 0);
        if (r < 35)
            return WEIGHT_W'($urandom_range(16777215, 10000000));
        if (safe && !fwd)
            return WEIGHT_W'($urandom_range(9999999, 1000));
        if (r < 60)
            return WEIGHT_W'($urandom_range(60, 0));
        if (r < 80)
        begin
            mag = $urandom_range(30, 1);
            return WEIGHT_W'(-mag);
        end
        if (safe)
            return WEIGHT_W'($urandom_range(9999999, 0));
        if (r < 95)
            return WEIGHT_W'($urandom);
        case ($urandom_range(3, 0))
            0: return W_MIN;
            1: return W_MAX;
            2: return 25'sd9999999;
            default: return 25'sd10000000;
        endcase
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_NODE_COUNT)
            nodes_reg = val;
        else
            src_reg = val[SRC_W-1:0];
    endtask

    task automatic send_entry(logic signed [WEIGHT_W-1:0] w, bit fin, bit keep);
        int g;
        @(negedge clk);
        in_valid <= 1'b1;
        edge_weight <= w;
        final_entry <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        take_weight(w, fin, keep);
        g = no_idle ? 0 : gap_len();
        if (g > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (g - 1)
                @(negedge clk);
        end
    endtask

    // drop valid first so the last beat is not taken again once the run ends
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout at cycle %0d", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{node, distance, negative_cycle, run_end};
            if (pending_results.size() == 0)
            begin
                if (bad_results < 10)
                    $display("unexpected result: node %0d dist %0d neg %0b end %0b",
                             node, distance, negative_cycle, run_end);
                bad_results++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    if (bad_results < 10)
                        $display({"mismatch: exp node %0d dist %0d neg %0b end %0b,",
                                  " got node %0d dist %0d neg %0b end %0b"},
                                 want.node, want.distance, want.negative_cycle,
                                 want.run_end, node, distance, negative_cycle, run_end);
                    bad_results++;
                end
            end
        end
    end

    initial
    begin : result_backpressure
        int free_run;
        int hold;
        out_stall = 1'b0;
        forever
        begin
            free_run = ($urandom_range(9, 0) == 0) ? $urandom_range(200, 50)
                                                  : $urandom_range(12, 1);
            hold = gap_len();
            repeat (free_run)
            begin
                @(negedge clk);
                out_stall <= 1'b0;
            end
            repeat (hold)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        int  e;
        int  len;
        int  seq_len;
        int  u;
        int  v;
        int  mode;
        int  r;
        int  rand_items;
        bit  safe;
        bit  whole;

        // single node: self loop decides the cycle flag
        plan[0]  = '{1'b1, 7'd1, 7'd0, 25'sd0, 1'b1, 1'b1, R_ZERO};
        plan[1]  = '{1'b0, 7'd0, 7'd0, W_MIN, 1'b1, 1'b1, R_CYCLE};
        plan[2]  = '{1'b0, 7'd0, 7'd0, W_MAX, 1'b1, 1'b1, R_ZERO};
        // count of zero acts as one node
        plan[3]  = '{1'b1, 7'd0, 7'd0, -25'sd1, 1'b1, 1'b1, R_CYCLE};
        // source past the node count: nothing reachable, so the negative self loop gives no cycle
        plan[4]  = '{1'b1, 7'd1, 7'd127, -25'sd3, 1'b1, 1'b1, R_UNREACH};
        // three nodes: path sum above the no-edge value gets clamped
        plan[5]  = '{1'b1, 7'd3, 7'd0, W_MAX, 1'b0, 1'b0, NO_RESULT};
        plan[6]  = '{1'b0, 7'd0, 7'd0, 25'sd9999999, 1'b0, 1'b0, NO_RESULT};
        plan[7]  = '{1'b0, 7'd0, 7'd0, 25'sd10000000, 1'b0, 1'b0, NO_RESULT};
        plan[8]  = '{1'b0, 7'd0, 7'd0, 25'sd10000000, 1'b0, 1'b0, NO_RESULT};
        plan[9]  = '{1'b0, 7'd0, 7'd0, W_MAX, 1'b0, 1'b0, NO_RESULT};
        plan[10] = '{1'b0, 7'd0, 7'd0, 25'sd9999999, 1'b0, 1'b0, NO_RESULT};
        plan[11] = '{1'b0, 7'd0, 7'd0, 25'sd10000000, 1'b0, 1'b0, NO_RESULT};
        plan[12] = '{1'b0, 7'd0, 7'd0, 25'sd10000000, 1'b0, 1'b0, NO_RESULT};
        plan[13] = '{1'b0, 7'd0, 7'd0, 25'sd10000000, 1'b1, 1'b0, NO_RESULT};
        // node 2 sits at exactly the no-edge distance yet still relaxes into a cycle
        plan[14] = '{1'b0, 7'd0, 7'd0, 25'sd10000000, 1'b0, 1'b0, NO_RESULT};
        plan[15] = '{1'b0, 7'd0, 7'd0, 25'sd9999999, 1'b0, 1'b0, NO_RESULT};
        plan[16] = '{1'b0, 7'd0, 7'd0, 25'sd10000000, 1'b0, 1'b0, NO_RESULT};
        plan[17] = '{1'b0, 7'd0, 7'd0, 25'sd10000000, 1'b0, 1'b0, NO_RESULT};
        plan[18] = '{1'b0, 7'd0, 7'd0, 25'sd10000000, 1'b0, 1'b0, NO_RESULT};
        plan[19] = '{1'b0, 7'd0, 7'd0, 25'sd1, 1'b0, 1'b0, NO_RESULT};
        plan[20] = '{1'b0, 7'd0, 7'd0, -25'sd10000001, 1'b0, 1'b0, NO_RESULT};
        plan[21] = '{1'b0, 7'd0, 7'd0, 25'sd10000000, 1'b0, 1'b0, NO_RESULT};
        plan[22] = '{1'b0, 7'd0, 7'd0, 25'sd10000000, 1'b1, 1'b1, R_CYCLE};

        repeat (8)
            @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < $size(plan); i++)
        begin
            if (plan[i].set_cfg)
            begin
                settle();
                write_reg(CFG_NODE_COUNT, plan[i].cnt);
                write_reg(CFG_SOURCE_NODE, plan[i].src);
            end
            // queued ahead of the beat so a fast result never beats the push
            if (plan[i].typed)
                pending_results.push_back(plan[i].want);
            send_entry(plan[i].w, plan[i].fin, !plan[i].typed);
        end

        rand_items = 0;
        while (rand_items < 450)
        begin
            no_idle = ($urandom_range(5, 0) == 0);
            settle();
            if (clip_nodes(nodes_reg) > 14 || $urandom_range(3, 0) != 0)
            begin
                r = $urandom_range(99, 0);
                if (r < 3)
                    write_reg(CFG_NODE_COUNT, 7'd0);
                else if (r < 80)
                    write_reg(CFG_NODE_COUNT, CFG_W'($urandom_range(5, 1)));
                else if (r < 95)
                    write_reg(CFG_NODE_COUNT, CFG_W'($urandom_range(9, 6)));
                else
                    write_reg(CFG_NODE_COUNT, CFG_W'($urandom_range(14, 10)));
            end
            e = clip_nodes(nodes_reg);
            if ($urandom_range(1, 0) == 1)
            begin
                if ($urandom_range(4, 0) == 0)
                    write_reg(CFG_SOURCE_NODE, CFG_W'($urandom_range(127, 0)));
                else
                    write_reg(CFG_SOURCE_NODE, CFG_W'($urandom_range(e - 1, 0)));
            end
            len = e * e;
            seq_len = len;
            mode = $urandom_range(99, 0);
            if (mode < 8 && len > 1)
            begin
                // early final beat: only when the tail of the matrix holds old data
                seq_len = $urandom_range(len - 1, 1);
                whole = 1'b1;
                for (int j = seq_len; j < len; j++)
                    if (!loaded[j])
                        whole = 1'b0;
                if (!whole)
                    seq_len = len;
            end
            else if (mode < 15)
                seq_len = len + $urandom_range(5, 1);
            safe = ($urandom_range(99, 0) < 65);
            for (int k = 0; k < seq_len; k++)
            begin
                u = (k % len) / e;
                v = (k % len) % e;
                send_entry(pick_weight(safe, v > u), k == seq_len - 1, 1'b1);
                rand_items++;
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200)
            @(posedge clk);
        if (bad_results == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
